FILE: hdl/iss_pkg.sv
// Shared types and constants for the integer stack with search.
// No dependencies; used by every other file of the block.
package iss_pkg;

	// field widths of the command and result words
	localparam int CMD_W     = 3;
	localparam int VALUE_W   = 32;
	localparam int INDEX_W   = 4;
	localparam int COUNT_W   = 5;
	localparam int CAP_W     = 5;

	// built depth and capacity after reset
	localparam int DEPTH_DEF = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_PEEK   = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_SEARCH = 3'd4
	} command_t;

	// shift control handed to every cell of the row
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctl_t;

endpackage

FILE: hdl/iss_cell.sv
// One cell of the stack row: holds one word and compares it with the search key.
// Depends on iss_pkg.
module iss_cell (
	input  logic                                clk,
	input  iss_pkg::shift_ctl_t                 ctl,
	input  logic signed [iss_pkg::VALUE_W-1:0]  word_above,
	input  logic signed [iss_pkg::VALUE_W-1:0]  word_below,
	input  logic signed [iss_pkg::VALUE_W-1:0]  key,
	input  logic                                live,
	output logic signed [iss_pkg::VALUE_W-1:0]  word,
	output logic                                match
);

	logic signed [iss_pkg::VALUE_W-1:0] word_q;

	// take the word from the cell above on push, from below on pop, else hold
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			word_q <= word_above;
		end else if (ctl.pop) begin
			word_q <= word_below;
		end
	end

	// flag a hit only while this cell holds a live entry
	assign match = live && (word_q == key);
	assign word  = word_q;

endmodule

FILE: hdl/integer_stack_with_search_unit.sv
// Integer LIFO stack with linear search: top level with the cell row and result register.
// Depends on iss_pkg and iss_cell.
// The result word is registered; it appears in the cycle after its command is accepted.
// Throughput: one command per cycle while in_stall is low; every cell compares at once
// and a priority pick over the row feeds the single result register.
// Reset clears the fill, the result valid and sets capacity to 16; words are not cleared.
module integer_stack_with_search_unit #(
	parameter int DEPTH = iss_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [iss_pkg::CAP_W-1:0]           cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [iss_pkg::CMD_W-1:0]           command,
	input  logic signed [iss_pkg::VALUE_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                ok,
	output logic signed [iss_pkg::VALUE_W-1:0]  data,
	output logic [iss_pkg::INDEX_W-1:0]         found_index,
	output logic [iss_pkg::COUNT_W-1:0]         count
);

	localparam int FW = $clog2(DEPTH + 1);
	localparam int W  = (FW > iss_pkg::COUNT_W) ? FW : iss_pkg::COUNT_W;

	logic [FW-1:0]                      fill_q, fill_d;
	logic [iss_pkg::CAP_W-1:0]          capacity_q;
	logic                               out_valid_q;
	logic                               ok_q, ok_d;
	logic signed [iss_pkg::VALUE_W-1:0] data_q, data_d;
	logic [iss_pkg::INDEX_W-1:0]        found_index_q, found_index_d;
	logic [iss_pkg::COUNT_W-1:0]        count_q;

	logic                               accept;
	iss_pkg::command_t                  cmd;
	iss_pkg::shift_ctl_t                ctl;
	logic                               push_go, pop_go;
	logic signed [iss_pkg::VALUE_W-1:0] row_word [DEPTH];
	logic [DEPTH-1:0]                   row_match;
	logic [DEPTH-1:0]                   row_live;
	logic [W-1:0]                       fill_w, cap_w, depth_w, hit_pos, idx_full, count_full;
	logic                               hit, can_push, non_empty;

	// stall input only while a result word waits to be taken
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign cmd      = iss_pkg::command_t'(command);

	assign fill_w    = W'(fill_q);
	assign cap_w     = W'(capacity_q);
	assign depth_w   = W'(DEPTH);
	assign can_push  = (fill_w < cap_w) && (fill_w < depth_w);
	assign non_empty = (fill_q != '0);

	// cell row; cell 0 is the top of the stack
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic signed [iss_pkg::VALUE_W-1:0] above, below;
		if (k == 0) begin : g_top
			assign above = value;
		end else begin : g_mid
			assign above = row_word[k-1];
		end
		if (k == DEPTH - 1) begin : g_bot
			assign below = row_word[k];
		end else begin : g_up
			assign below = row_word[k+1];
		end
		assign row_live[k] = W'(k) < fill_w;
		iss_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.word_above (above),
			.word_below (below),
			.key        (value),
			.live       (row_live[k]),
			.word       (row_word[k]),
			.match      (row_match[k])
		);
	end

	// pick the deepest matching cell, which is the lowest bottom-based index
	always_comb begin
		hit     = 1'b0;
		hit_pos = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (row_match[k]) begin
				hit     = 1'b1;
				hit_pos = W'(k);
			end
		end
	end

	assign idx_full = fill_w - W'(1) - hit_pos;

	// decode the command
	always_comb begin
		ok_d          = 1'b0;
		data_d        = '0;
		found_index_d = '0;
		fill_d        = fill_q;
		push_go       = 1'b0;
		pop_go        = 1'b0;
		unique case (cmd)
			iss_pkg::CMD_PUSH: begin
				if (can_push) begin
					push_go = 1'b1;
					fill_d  = fill_q + FW'(1);
					ok_d    = 1'b1;
				end
			end
			iss_pkg::CMD_POP: begin
				if (non_empty) begin
					pop_go = 1'b1;
					fill_d = fill_q - FW'(1);
					data_d = row_word[0];
					ok_d   = 1'b1;
				end
			end
			iss_pkg::CMD_PEEK: begin
				if (non_empty) begin
					data_d = row_word[0];
					ok_d   = 1'b1;
				end
			end
			iss_pkg::CMD_CLEAR: begin
				fill_d = '0;
				ok_d   = 1'b1;
			end
			iss_pkg::CMD_SEARCH: begin
				if (hit) begin
					ok_d          = 1'b1;
					found_index_d = idx_full[iss_pkg::INDEX_W-1:0];
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	assign ctl.push   = accept && push_go;
	assign ctl.pop    = accept && pop_go;
	assign count_full = W'(fill_d);

	// control state: fill, capacity, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			capacity_q  <= iss_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			if (accept) begin
				fill_q      <= fill_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word; load on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q          <= ok_d;
			data_q        <= data_d;
			found_index_q <= found_index_d;
			count_q       <= count_full[iss_pkg::COUNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign data        = data_q;
	assign found_index = found_index_q;
	assign count       = count_q;

endmodule

FILE: hdl/iss_checker.sv
// Port-level checks for the integer stack with search, bound to the top level.
// Depends on iss_pkg and integer_stack_with_search_unit.
module iss_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [iss_pkg::CMD_W-1:0]           command,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                ok,
	input  logic signed [iss_pkg::VALUE_W-1:0]  data,
	input  logic [iss_pkg::INDEX_W-1:0]         found_index,
	input  logic [iss_pkg::COUNT_W-1:0]         count
);

	// input stalls only behind a held result word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with no held result word");

	// a held result word keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(ok) && $stable(data)
			&& $stable(found_index) && $stable(count)))
		else $error("held result word changed");

	// a failed command carries zero data and zero index
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (data == '0 && found_index == '0))
		else $error("failed result word carries data");

	// an accepted clear empties the stack
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command == iss_pkg::CMD_CLEAR)
			|=> (out_valid && ok && count == '0))
		else $error("clear did not empty the stack");

endmodule

bind integer_stack_with_search_unit iss_checker u_iss_checker (.*);
